### rtl/wavh_pkg.sv
// Shared types and constants for the WAV header parser.
package wavh_pkg;

   // Result status codes
   localparam logic [3:0] ST_VALID     = 4'd0;
   localparam logic [3:0] ST_RIFF      = 4'd1;
   localparam logic [3:0] ST_WAVE      = 4'd2;
   localparam logic [3:0] ST_FMT_ID    = 4'd3;
   localparam logic [3:0] ST_TAG       = 4'd4;
   localparam logic [3:0] ST_CHANNELS  = 4'd5;
   localparam logic [3:0] ST_RATE      = 4'd6;
   localparam logic [3:0] ST_BITS      = 4'd7;
   localparam logic [3:0] ST_EXTRA     = 4'd8;
   localparam logic [3:0] ST_FACT      = 4'd9;
   localparam logic [3:0] ST_DATA_ID   = 4'd10;
   localparam logic [3:0] ST_TOO_LONG  = 4'd11;

   // Chunk tags as seen in the little-endian word window
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_LEN_PLAIN = 32'h0000_0010;
   localparam logic [15:0] FMT_PCM       = 16'd1;
   localparam logic [15:0] MONO          = 16'd1;
   localparam logic [15:0] BITS_8        = 16'd8;
   localparam logic [15:0] EXTRA_NONE    = 16'h0000;

   localparam logic [31:0] RATE_8000  = 32'd8000;
   localparam logic [31:0] RATE_11025 = 32'd11025;
   localparam logic [31:0] RATE_22050 = 32'd22050;
   localparam logic [31:0] RATE_44100 = 32'd44100;

   // Configuration register indexes and reset values
   localparam logic [1:0] REG_RELOAD_8000  = 2'd0;
   localparam logic [1:0] REG_RELOAD_11025 = 2'd1;
   localparam logic [1:0] REG_RELOAD_22050 = 2'd2;
   localparam logic [1:0] REG_RELOAD_44100 = 2'd3;

   localparam logic [15:0] RELOAD_8000_RST  = 16'd937;
   localparam logic [15:0] RELOAD_11025_RST = 16'd4353;
   localparam logic [15:0] RELOAD_22050_RST = 16'd2176;
   localparam logic [15:0] RELOAD_44100_RST = 16'd1088;

   typedef struct packed {
      logic [15:0] rate_8000;
      logic [15:0] rate_11025;
      logic [15:0] rate_22050;
      logic [15:0] rate_44100;
   } reload_set_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] timer_reload;
      logic [31:0] riff_size;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [31:0] data_size;
   } result_type;

endpackage

### rtl/wavh_req_if.sv
// Request channel: one header byte per transfer.
interface wavh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       first_byte;

   modport source (output valid, output header_byte, output first_byte, input ready);
   modport sink   (input valid, input header_byte, input first_byte, output ready);
endinterface

### rtl/wavh_rsp_if.sv
// Response channel: one parse result per transfer.
interface wavh_rsp_if #(
   parameter int OFS_W = 9
);
   logic             valid;
   logic             ready;
   logic [3:0]       status;
   logic [15:0]      timer_reload;
   logic [31:0]      riff_size;
   logic [31:0]      byte_rate;
   logic [15:0]      block_align;
   logic [31:0]      data_size;
   logic [OFS_W-1:0] data_offset;

   modport source (output valid, output status, output timer_reload, output riff_size,
                   output byte_rate, output block_align, output data_size,
                   output data_offset, input ready);
   modport sink   (input valid, input status, input timer_reload, input riff_size,
                   input byte_rate, input block_align, input data_size,
                   input data_offset, output ready);
endinterface

### rtl/wavh_parse.sv
// Per-byte header parse state and the result decision for each byte.
module wavh_parse #(
   parameter int MAX_HEADER_BYTES = 256,
   parameter int PW               = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_fire,
   input  logic [7:0]              header_byte,
   input  logic                    first_byte,
   input  wavh_pkg::reload_set_type reloads,
   output logic                    res_fire,
   output wavh_pkg::result_type    res,
   output logic [PW-1:0]           res_offset
);

   localparam bit FACT_NO_ROOM = (54 > MAX_HEADER_BYTES);
   localparam bit PLAIN_NO_ROOM = (44 > MAX_HEADER_BYTES);
   localparam logic [33:0] MAX_BYTES = 34'(MAX_HEADER_BYTES);

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   ww_ff, ww_in;
   logic          done_ff, done_in;
   logic          fact_ff, fact_in;
   logic [PW-1:0] dtp_ff, dtp_in;
   logic [15:0]   reload_ff, reload_in;
   logic [31:0]   riff_ff, riff_in;
   logic [31:0]   brate_ff, brate_in;
   logic [15:0]   align_ff, align_in;

   // effective state after a possible restart
   logic [PW-1:0] pos_e, dtp_e;
   logic [31:0]   ww_e, riff_e, brate_e;
   logic          done_e, fact_e;
   logic [15:0]   reload_e, align_e;
   logic [31:0]   new_ww;
   logic [15:0]   hi16;
   logic          fail;
   logic [3:0]    fail_code;
   logic          finish_ok;
   logic [33:0]   fact_end;

   always_comb begin
      pos_e    = first_byte ? '0 : pos_ff;
      ww_e     = first_byte ? '0 : ww_ff;
      done_e   = first_byte ? 1'b0 : done_ff;
      fact_e   = first_byte ? 1'b0 : fact_ff;
      dtp_e    = first_byte ? '0 : dtp_ff;
      reload_e = first_byte ? '0 : reload_ff;
      riff_e   = first_byte ? '0 : riff_ff;
      brate_e  = first_byte ? '0 : brate_ff;
      align_e  = first_byte ? '0 : align_ff;

      new_ww   = {header_byte, ww_e[31:8]};
      hi16     = new_ww[31:16];
      fact_end = {2'b00, new_ww} + 34'd54;

      pos_in    = pos_e + PW'(1);
      ww_in     = new_ww;
      done_in   = done_e;
      fact_in   = fact_e;
      dtp_in    = dtp_e;
      reload_in = reload_e;
      riff_in   = riff_e;
      brate_in  = brate_e;
      align_in  = align_e;
      fail      = 1'b0;
      fail_code = wavh_pkg::ST_VALID;
      finish_ok = 1'b0;

      if (done_e) begin
         // idle: hold everything
         pos_in = pos_ff;
         ww_in  = ww_ff;
      end else begin
         if (pos_e == PW'(3)) begin
            if (new_ww != wavh_pkg::TAG_RIFF) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_RIFF;
            end
         end else if (pos_e == PW'(7)) begin
            riff_in = new_ww;
         end else if (pos_e == PW'(11)) begin
            if (new_ww != wavh_pkg::TAG_WAVE) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_WAVE;
            end
         end else if (pos_e == PW'(15)) begin
            if (new_ww != wavh_pkg::TAG_FMT) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_FMT_ID;
            end
         end else if (pos_e == PW'(19)) begin
            fact_in = (new_ww != wavh_pkg::FMT_LEN_PLAIN);
         end else if (pos_e == PW'(21)) begin
            if (hi16 != wavh_pkg::FMT_PCM) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_TAG;
            end
         end else if (pos_e == PW'(23)) begin
            if (hi16 != wavh_pkg::MONO) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_CHANNELS;
            end
         end else if (pos_e == PW'(27)) begin
            if (new_ww == wavh_pkg::RATE_8000)       reload_in = reloads.rate_8000;
            else if (new_ww == wavh_pkg::RATE_11025) reload_in = reloads.rate_11025;
            else if (new_ww == wavh_pkg::RATE_22050) reload_in = reloads.rate_22050;
            else if (new_ww == wavh_pkg::RATE_44100) reload_in = reloads.rate_44100;
            else begin
               fail = 1'b1; fail_code = wavh_pkg::ST_RATE;
            end
         end else if (pos_e == PW'(31)) begin
            brate_in = new_ww;
         end else if (pos_e == PW'(33)) begin
            align_in = hi16;
         end else if (pos_e == PW'(35)) begin
            if (hi16 != wavh_pkg::BITS_8) begin
               fail = 1'b1; fail_code = wavh_pkg::ST_BITS;
            end else if (fact_e) begin
               if (FACT_NO_ROOM) begin
                  fail = 1'b1; fail_code = wavh_pkg::ST_TOO_LONG;
               end
            end else begin
               dtp_in = PW'(36);
               if (PLAIN_NO_ROOM) begin
                  fail = 1'b1; fail_code = wavh_pkg::ST_TOO_LONG;
               end
            end
         end else if (pos_e >= PW'(36)) begin
            if (fact_e && pos_e < PW'(46)) begin
               // extra-bytes word and fact chunk header; the body is skipped
               if (pos_e == PW'(37) && hi16 != wavh_pkg::EXTRA_NONE) begin
                  fail = 1'b1; fail_code = wavh_pkg::ST_EXTRA;
               end else if (pos_e == PW'(41) && new_ww != wavh_pkg::TAG_FACT) begin
                  fail = 1'b1; fail_code = wavh_pkg::ST_FACT;
               end else if (pos_e == PW'(45)) begin
                  if (fact_end > MAX_BYTES) begin
                     fail = 1'b1; fail_code = wavh_pkg::ST_TOO_LONG;
                  end else begin
                     dtp_in = PW'(new_ww) + PW'(46);
                  end
               end
            end else if (pos_e == dtp_e + PW'(3)) begin
               if (new_ww != wavh_pkg::TAG_DATA) begin
                  fail = 1'b1; fail_code = wavh_pkg::ST_DATA_ID;
               end
            end else if (pos_e == dtp_e + PW'(7)) begin
               finish_ok = 1'b1;
            end
         end
         if (fail || finish_ok) begin
            done_in = 1'b1;
         end
      end

      res_fire = in_fire && (fail || finish_ok);
      res      = '0;
      res_offset = '0;
      if (fail) begin
         res.status = fail_code;
      end else begin
         res.status       = wavh_pkg::ST_VALID;
         res.timer_reload = reload_e;
         res.riff_size    = riff_e;
         res.byte_rate    = brate_e;
         res.block_align  = align_e;
         res.data_size    = new_ww;
         res_offset       = dtp_e + PW'(8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         ww_ff     <= '0;
         done_ff   <= 1'b1;
         fact_ff   <= 1'b0;
         dtp_ff    <= '0;
         reload_ff <= '0;
         riff_ff   <= '0;
         brate_ff  <= '0;
         align_ff  <= '0;
      end else if (in_fire) begin
         pos_ff    <= pos_in;
         ww_ff     <= ww_in;
         done_ff   <= done_in;
         fact_ff   <= fact_in;
         dtp_ff    <= dtp_in;
         reload_ff <= reload_in;
         riff_ff   <= riff_in;
         brate_ff  <= brate_in;
         align_ff  <= align_in;
      end
   end

endmodule

### rtl/wav_header_parser.sv
// WAV header parser top level: channels, reload registers and result register.
//
// Feed the header of a WAV file one byte per transfer on req_if, setting
// first_byte on byte zero to start a parse. The block checks the RIFF/WAVE/fmt
// chunks (PCM, mono, 8 bits, 8000/11025/22050/44100 Hz), an optional fact
// chunk and the data tag, and returns one transfer on rsp_if at the first
// error or once the data size field is complete. Bytes after that result are
// dropped until the next first_byte.
// Throughput: one byte per cycle while req_if is ready. Each byte is decoded
// in the cycle it is taken; a result appears on rsp_if in the cycle after the
// byte that closes the header, held in an output register.
// A stalled receiver holds the result; req_if stays ready while that register
// is empty or being drained in the same cycle.
// Reset restores the reload registers to their defaults and leaves the parser
// idle until a first byte arrives. The csr_ registers are sampled when the
// sample rate field completes.
module wav_header_parser #(
   parameter int MAX_HEADER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   wavh_req_if.sink    req_if,
   wavh_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int PW = $clog2(MAX_HEADER_BYTES + 1);

   wavh_pkg::reload_set_type reloads_ff;
   wavh_pkg::result_type     res;
   wavh_pkg::result_type     rsp_ff;
   logic [PW-1:0]            res_offset;
   logic [PW-1:0]            offset_ff;
   logic                     rsp_valid_ff;
   logic                     res_fire;
   logic                     in_fire;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign in_fire      = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reloads_ff.rate_8000  <= wavh_pkg::RELOAD_8000_RST;
         reloads_ff.rate_11025 <= wavh_pkg::RELOAD_11025_RST;
         reloads_ff.rate_22050 <= wavh_pkg::RELOAD_22050_RST;
         reloads_ff.rate_44100 <= wavh_pkg::RELOAD_44100_RST;
      end else if (csr_we) begin
         case (csr_index)
            wavh_pkg::REG_RELOAD_8000:  reloads_ff.rate_8000  <= csr_wdata;
            wavh_pkg::REG_RELOAD_11025: reloads_ff.rate_11025 <= csr_wdata;
            wavh_pkg::REG_RELOAD_22050: reloads_ff.rate_22050 <= csr_wdata;
            wavh_pkg::REG_RELOAD_44100: reloads_ff.rate_44100 <= csr_wdata;
            default: ;
         endcase
      end
   end

   wavh_parse #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
      .PW               (PW)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .header_byte (req_if.header_byte),
      .first_byte  (req_if.first_byte),
      .reloads     (reloads_ff),
      .res_fire    (res_fire),
      .res         (res),
      .res_offset  (res_offset)
   );

   // Output register: load on a closing byte, drop on a taken transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_ff    <= res;
         offset_ff <= res_offset;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_ff.status;
   assign rsp_if.timer_reload = rsp_ff.timer_reload;
   assign rsp_if.riff_size    = rsp_ff.riff_size;
   assign rsp_if.byte_rate    = rsp_ff.byte_rate;
   assign rsp_if.block_align  = rsp_ff.block_align;
   assign rsp_if.data_size    = rsp_ff.data_size;
   assign rsp_if.data_offset  = offset_ff;

endmodule

### tb/tb_wav_header_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for the WAV header parser: table-driven headers, then random streams.
module tb_wav_header_parser;

   localparam int HDR_LIMIT = 256;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] timer_reload;
      logic [31:0] riff_size;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [31:0] data_size;
      logic [8:0]  data_offset;
   } outcome_type;

   typedef enum logic [3:0] {
      FLT_NONE, FLT_RIFF, FLT_WAVE, FLT_FMT, FLT_FORMAT, FLT_CHANNELS, FLT_RATE, FLT_BITS,
      FLT_EXTRA, FLT_FACT, FLT_DATA, FLT_RESTART, FLT_STRAY
   } fault_kind_type;

   typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_kind_type;

   typedef struct packed {
      fault_kind_type fault;
      bit             with_fact;
      logic [1:0]     rate_sel;
      logic [31:0]    fact_len;
      fill_kind_type  fill;
      bit             typed;
      outcome_type    want;
   } header_case_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   wavh_req_if req_bus ();
   wavh_rsp_if #(.OFS_W(9)) rsp_bus ();

   wav_header_parser #(.MAX_HEADER_BYTES(HDR_LIMIT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // parser state as the block should hold it
   int unsigned p_pos;
   logic [31:0] p_window;
   bit          p_done;
   bit          p_fact;
   int unsigned p_tag_pos;
   logic [15:0] p_reload;
   logic [31:0] p_riff;
   logic [31:0] p_brate;
   logic [15:0] p_align;
   logic [15:0] reload_cfg [4];

   outcome_type     pending_results [$];
   bit              typed_pending;
   outcome_type     typed_want;
   int              fail_count;
   int              results_seen;
   int              bytes_parsed;
   int              send_idle_pct;
   int              recv_stall_pct;
   logic [7:0]      hdr_bytes [$];
   header_case_type directed_cases [22];

   always #1 clock = ~clock;

   function automatic void clear_parse();
      p_pos     = 0;
      p_window  = '0;
      p_fact    = 1'b0;
      p_tag_pos = 0;
      p_reload  = '0;
      p_riff    = '0;
      p_brate   = '0;
      p_align   = '0;
   endfunction

   function automatic outcome_type close_parse(input logic [3:0] st, input logic [31:0] dsize);
      outcome_type r;
      r = '0;
      r.status = st;
      if (st == wavh_pkg::ST_VALID) begin
         r.timer_reload = p_reload;
         r.riff_size    = p_riff;
         r.byte_rate    = p_brate;
         r.block_align  = p_align;
         r.data_size    = dsize;
         r.data_offset  = 9'(p_tag_pos + 8);
      end
      p_done = 1'b1;
      return r;
   endfunction

   // Advance the parse by one byte; return 1 when the byte closes the header.
   function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                     output outcome_type res);
      logic [15:0]     hi;
      int unsigned     at;
      longint unsigned span;
      res = '0;
      if (first) begin
         clear_parse();
         p_done = 1'b0;
      end
      if (p_done) return 1'b0;
      at = p_pos;
      p_pos++;
      bytes_parsed++;
      p_window = {b, p_window[31:8]};
      hi = p_window[31:16];
      case (at)
         3: if (p_window != wavh_pkg::TAG_RIFF) begin
            res = close_parse(wavh_pkg::ST_RIFF, '0);
            return 1'b1;
         end
         7: p_riff = p_window;
         11: if (p_window != wavh_pkg::TAG_WAVE) begin
            res = close_parse(wavh_pkg::ST_WAVE, '0);
            return 1'b1;
         end
         15: if (p_window != wavh_pkg::TAG_FMT) begin
            res = close_parse(wavh_pkg::ST_FMT_ID, '0);
            return 1'b1;
         end
         19: p_fact = (p_window != wavh_pkg::FMT_LEN_PLAIN);
         21: if (hi != wavh_pkg::FMT_PCM) begin
            res = close_parse(wavh_pkg::ST_TAG, '0);
            return 1'b1;
         end
         23: if (hi != wavh_pkg::MONO) begin
            res = close_parse(wavh_pkg::ST_CHANNELS, '0);
            return 1'b1;
         end
         27: begin
            if (p_window == wavh_pkg::RATE_8000)
               p_reload = reload_cfg[wavh_pkg::REG_RELOAD_8000];
            else if (p_window == wavh_pkg::RATE_11025)
               p_reload = reload_cfg[wavh_pkg::REG_RELOAD_11025];
            else if (p_window == wavh_pkg::RATE_22050)
               p_reload = reload_cfg[wavh_pkg::REG_RELOAD_22050];
            else if (p_window == wavh_pkg::RATE_44100)
               p_reload = reload_cfg[wavh_pkg::REG_RELOAD_44100];
            else begin
               res = close_parse(wavh_pkg::ST_RATE, '0);
               return 1'b1;
            end
         end
         31: p_brate = p_window;
         33: p_align = hi;
         35: begin
            if (hi != wavh_pkg::BITS_8) begin
               res = close_parse(wavh_pkg::ST_BITS, '0);
               return 1'b1;
            end
            if (p_fact) begin
               if (54 > HDR_LIMIT) begin
                  res = close_parse(wavh_pkg::ST_TOO_LONG, '0);
                  return 1'b1;
               end
            end else begin
               p_tag_pos = 36;
               if (44 > HDR_LIMIT) begin
                  res = close_parse(wavh_pkg::ST_TOO_LONG, '0);
                  return 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (at < 36) return 1'b0;
      if (p_fact && at < 46) begin
         if (at == 37 && hi != wavh_pkg::EXTRA_NONE) begin
            res = close_parse(wavh_pkg::ST_EXTRA, '0);
            return 1'b1;
         end
         if (at == 41 && p_window != wavh_pkg::TAG_FACT) begin
            res = close_parse(wavh_pkg::ST_FACT, '0);
            return 1'b1;
         end
         if (at == 45) begin
            // full 32-bit fact size, no wrap
            span = 64'd54 + longint'(p_window);
            if (span > HDR_LIMIT) begin
               res = close_parse(wavh_pkg::ST_TOO_LONG, '0);
               return 1'b1;
            end
            p_tag_pos = 46 + p_window;
         end
         return 1'b0;
      end
      if (at == p_tag_pos + 3) begin
         if (p_window != wavh_pkg::TAG_DATA) begin
            res = close_parse(wavh_pkg::ST_DATA_ID, '0);
            return 1'b1;
         end
      end else if (at == p_tag_pos + 7) begin
         res = close_parse(wavh_pkg::ST_VALID, p_window);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (parse_byte(req_bus.header_byte, req_bus.first_byte, got)) begin
               if (typed_pending) begin
                  pending_results.push_back(typed_want);
                  typed_pending = 1'b0;
               end else begin
                  pending_results.push_back(got);
               end
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing expected, status %0d", rsp_bus.status);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("timer_reload", 32'(want.timer_reload),
                           32'(rsp_bus.timer_reload));
               check_field("riff_size", want.riff_size, rsp_bus.riff_size);
               check_field("byte_rate", want.byte_rate, rsp_bus.byte_rate);
               check_field("block_align", 32'(want.block_align), 32'(rsp_bus.block_align));
               check_field("data_size", want.data_size, rsp_bus.data_size);
               check_field("data_offset", 32'(want.data_offset), 32'(rsp_bus.data_offset));
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   function automatic outcome_type error_of(input logic [3:0] st);
      outcome_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   function automatic logic [31:0] fill_word(input fill_kind_type f);
      case (f)
         FILL_ZERO: return '0;
         FILL_ONES: return '1;
         default:   return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rate_word(input logic [1:0] sel);
      case (sel)
         2'd0:    return wavh_pkg::RATE_8000;
         2'd1:    return wavh_pkg::RATE_11025;
         2'd2:    return wavh_pkg::RATE_22050;
         default: return wavh_pkg::RATE_44100;
      endcase
   endfunction

   // Byte that exposes a planted fault; send_case trims the bytes after it.
   function automatic int fault_end(input fault_kind_type f, input int data_at);
      case (f)
         FLT_RIFF:     return 3;
         FLT_WAVE:     return 11;
         FLT_FMT:      return 15;
         FLT_FORMAT:   return 21;
         FLT_CHANNELS: return 23;
         FLT_RATE:     return 27;
         FLT_BITS:     return 35;
         FLT_EXTRA:    return 37;
         FLT_FACT:     return 41;
         FLT_DATA:     return data_at + 3;
         default:      return -1;
      endcase
   endfunction

   function automatic void push_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) hdr_bytes.push_back(v[8*i +: 8]);
   endfunction

   // Lay out a well-formed header; return where the data tag starts.
   function automatic int build_header(input header_case_type c);
      logic [31:0] fmt_len;
      int          body;
      int          data_at;
      hdr_bytes.delete();
      push_le(wavh_pkg::TAG_RIFF, 4);
      push_le(fill_word(c.fill), 4);
      push_le(wavh_pkg::TAG_WAVE, 4);
      push_le(wavh_pkg::TAG_FMT, 4);
      fmt_len = wavh_pkg::FMT_LEN_PLAIN;
      if (c.with_fact) begin
         fmt_len = fill_word(c.fill);
         if (fmt_len == wavh_pkg::FMT_LEN_PLAIN) fmt_len = 32'd18;
      end
      push_le(fmt_len, 4);
      push_le(32'(wavh_pkg::FMT_PCM), 2);
      push_le(32'(wavh_pkg::MONO), 2);
      push_le(rate_word(c.rate_sel), 4);
      push_le(fill_word(c.fill), 4);
      push_le(fill_word(c.fill), 2);
      push_le(32'(wavh_pkg::BITS_8), 2);
      if (c.with_fact) begin
         push_le(32'(wavh_pkg::EXTRA_NONE), 2);
         push_le(wavh_pkg::TAG_FACT, 4);
         push_le(c.fact_len, 4);
         // a fact body that cannot fit is rejected before it starts
         body = (c.fact_len > 32'(HDR_LIMIT - 54)) ? 0 : int'(c.fact_len);
         for (int i = 0; i < body; i++) push_le(fill_word(c.fill), 1);
      end
      data_at = hdr_bytes.size();
      push_le(wavh_pkg::TAG_DATA, 4);
      push_le(fill_word(c.fill), 4);
      return data_at;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.header_byte <= b;
      req_bus.first_byte  <= first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_case(input header_case_type c, input bit noisy);
      int   data_at;
      int   at;
      int   n;
      int   stop;
      logic first;
      data_at = build_header(c);
      at = -1;
      case (c.fault)
         FLT_RIFF:     at = $urandom_range(0, 3);
         FLT_WAVE:     at = 8 + $urandom_range(0, 3);
         FLT_FMT:      at = 12 + $urandom_range(0, 3);
         FLT_FORMAT:   at = 20 + $urandom_range(0, 1);
         FLT_CHANNELS: at = 22 + $urandom_range(0, 1);
         FLT_RATE:     at = 24 + $urandom_range(0, 3);
         FLT_BITS:     at = 34 + $urandom_range(0, 1);
         FLT_EXTRA:    at = 36 + $urandom_range(0, 1);
         FLT_FACT:     at = 38 + $urandom_range(0, 3);
         FLT_DATA:     at = data_at + $urandom_range(0, 3);
         FLT_RESTART: begin
            n = $urandom_range(1, 40);
            while (hdr_bytes.size() > n) void'(hdr_bytes.pop_back());
         end
         FLT_STRAY: begin
            hdr_bytes.delete();
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) hdr_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
      if (at >= 0) hdr_bytes[at] = hdr_bytes[at] ^ 8'($urandom_range(1, 255));
      stop = fault_end(c.fault, data_at);
      if (stop >= 0) begin
         while (hdr_bytes.size() > stop + 1) void'(hdr_bytes.pop_back());
      end
      if (noisy) begin
         if ($urandom_range(0, 99) < 8) begin
            at = $urandom_range(0, hdr_bytes.size() - 1);
            hdr_bytes[at] = 8'($urandom);
         end
         // trailing bytes after the result are dropped by the block
         if ($urandom_range(0, 99) < 20) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) hdr_bytes.push_back(8'($urandom));
         end
      end
      for (int i = 0; i < hdr_bytes.size(); i++) begin
         if (c.fault == FLT_STRAY) first = noisy && ($urandom_range(0, 3) == 0);
         else first = (i == 0);
         send_byte(hdr_bytes[i], first);
         // arm the typed expectation once the restart byte is in
         if (i == 0 && c.typed) begin
            typed_want    = c.want;
            typed_pending = 1'b1;
         end
      end
   endtask

   function automatic header_case_type random_case();
      header_case_type c;
      int              k;
      c = '0;
      k = $urandom_range(0, 99);
      if (k < 45) c.fault = FLT_NONE;
      else if (k < 52) c.fault = FLT_RESTART;
      else if (k < 57) c.fault = FLT_STRAY;
      else c.fault = fault_kind_type'($urandom_range(FLT_RIFF, FLT_DATA));
      c.with_fact = 1'($urandom_range(0, 1));
      if (c.fault == FLT_EXTRA || c.fault == FLT_FACT) c.with_fact = 1'b1;
      c.rate_sel = 2'($urandom_range(0, 3));
      k = $urandom_range(0, 99);
      if (k < 5) c.fill = FILL_ZERO;
      else if (k < 10) c.fill = FILL_ONES;
      else c.fill = FILL_RAND;
      k = $urandom_range(0, 99);
      if (k < 70) c.fact_len = $urandom_range(0, 12);
      else if (k < 80) c.fact_len = $urandom_range(190, 202);
      else if (k < 90) c.fact_len = $urandom_range(203, 255);
      else c.fact_len = $urandom;
      return c;
   endfunction

   // Drop valid, then hold until every result is back and the block has settled.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reload(input logic [1:0] idx, input logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      reload_cfg[idx] = v;
   endtask

   task automatic write_reloads(input logic [15:0] v8, input logic [15:0] v11,
                                input logic [15:0] v22, input logic [15:0] v44);
      write_reload(wavh_pkg::REG_RELOAD_8000, v8);
      write_reload(wavh_pkg::REG_RELOAD_11025, v11);
      write_reload(wavh_pkg::REG_RELOAD_22050, v22);
      write_reload(wavh_pkg::REG_RELOAD_44100, v44);
   endtask

   initial begin
      int byte_goal;
      int mid_goal;
      int result_goal;
      bit mid_done;
      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.header_byte = '0;
      req_bus.first_byte  = 1'b0;
      rsp_bus.ready       = 1'b0;
      fail_count          = 0;
      results_seen        = 0;
      bytes_parsed        = 0;
      typed_pending       = 1'b0;
      typed_want          = '0;
      send_idle_pct       = 19;
      recv_stall_pct      = 81;
      reload_cfg[wavh_pkg::REG_RELOAD_8000]  = wavh_pkg::RELOAD_8000_RST;
      reload_cfg[wavh_pkg::REG_RELOAD_11025] = wavh_pkg::RELOAD_11025_RST;
      reload_cfg[wavh_pkg::REG_RELOAD_22050] = wavh_pkg::RELOAD_22050_RST;
      reload_cfg[wavh_pkg::REG_RELOAD_44100] = wavh_pkg::RELOAD_44100_RST;
      clear_parse();
      p_done = 1'b1;

      directed_cases = '{
         '{FLT_STRAY,    1'b0, 2'd0, 32'd0, FILL_RAND, 1'b0, '0},
         '{FLT_NONE,     1'b0, 2'd0, 32'd0, FILL_ZERO, 1'b1,
           '{wavh_pkg::ST_VALID, wavh_pkg::RELOAD_8000_RST, 32'h0, 32'h0, 16'h0, 32'h0,
             9'd44}},
         '{FLT_NONE,     1'b0, 2'd1, 32'd0, FILL_ONES, 1'b1,
           '{wavh_pkg::ST_VALID, wavh_pkg::RELOAD_11025_RST, '1, '1, '1, '1, 9'd44}},
         '{FLT_NONE,     1'b0, 2'd2, 32'd0, FILL_RAND, 1'b0, '0},
         '{FLT_NONE,     1'b0, 2'd3, 32'd0, FILL_RAND, 1'b0, '0},
         '{FLT_RIFF,     1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_RIFF)},
         '{FLT_WAVE,     1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_WAVE)},
         '{FLT_FMT,      1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_FMT_ID)},
         '{FLT_FORMAT,   1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_TAG)},
         '{FLT_CHANNELS, 1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1,
           error_of(wavh_pkg::ST_CHANNELS)},
         '{FLT_RATE,     1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_RATE)},
         '{FLT_BITS,     1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1, error_of(wavh_pkg::ST_BITS)},
         '{FLT_EXTRA,    1'b1, 2'd0, 32'd0, FILL_ZERO, 1'b1, error_of(wavh_pkg::ST_EXTRA)},
         '{FLT_FACT,     1'b1, 2'd0, 32'd0, FILL_ZERO, 1'b1, error_of(wavh_pkg::ST_FACT)},
         '{FLT_DATA,     1'b0, 2'd0, 32'd0, FILL_RAND, 1'b1,
           error_of(wavh_pkg::ST_DATA_ID)},
         '{FLT_NONE,     1'b1, 2'd0, 32'd0, FILL_ZERO, 1'b1,
           '{wavh_pkg::ST_VALID, wavh_pkg::RELOAD_8000_RST, 32'h0, 32'h0, 16'h0, 32'h0,
             9'd54}},
         '{FLT_NONE,     1'b1, 2'd3, 32'd202, FILL_RAND, 1'b0, '0},
         '{FLT_NONE,     1'b1, 2'd1, 32'd203, FILL_RAND, 1'b1,
           error_of(wavh_pkg::ST_TOO_LONG)},
         '{FLT_NONE,     1'b1, 2'd2, 32'hFFFF_FFFF, FILL_RAND, 1'b1,
           error_of(wavh_pkg::ST_TOO_LONG)},
         '{FLT_RESTART,  1'b0, 2'd0, 32'd0, FILL_RAND, 1'b0, '0},
         '{FLT_DATA,     1'b1, 2'd1, 32'd5, FILL_RAND, 1'b1,
           error_of(wavh_pkg::ST_DATA_ID)},
         '{FLT_STRAY,    1'b0, 2'd0, 32'd0, FILL_RAND, 1'b0, '0}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_cases); i++) send_case(directed_cases[i], 1'b0);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 19;
               recv_stall_pct = 81;
               write_reloads('0, '0, '0, '0);
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 19;
               write_reloads('1, '1, '1, '1);
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_reloads(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
         endcase
         byte_goal   = bytes_parsed + 60;
         mid_goal    = bytes_parsed + 30;
         result_goal = results_seen + 1;
         mid_done    = 1'b0;
         while (bytes_parsed < byte_goal || results_seen < result_goal) begin
            send_case(random_case(), 1'b1);
            if (!mid_done && bytes_parsed >= mid_goal) begin
               // hold the sender until the receiver has caught up, then retune
               drain_results();
               write_reloads(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
               mid_done = 1'b1;
            end
         end
         drain_results();
      end

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
